>>> hdl/fndf_pkg.sv
// ---------------------------------------------------------------------------
// fndf_pkg
// Shared widths, constants and types of the four-neighbour deglitch filter.
// ---------------------------------------------------------------------------
package fndf_pkg;

   // pixel and arithmetic widths
   localparam int PIX_W      = 8;
   localparam int SUM_W      = PIX_W + 2;
   localparam int CNT_W      = 3;
   // divide by three: multiply by ceil(2^k/3), exact for every sum of SUM_W bits
   localparam int DIV3_SHIFT = SUM_W + 1;
   localparam int DIV3_MUL   = ((2 ** DIV3_SHIFT) + 2) / 3;
   localparam int PROD_W     = SUM_W + DIV3_SHIFT;

   // geometry
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int FW_W          = 11;
   localparam int FH_W          = 16;
   localparam int ROW_W         = 16;
   localparam int OCOL_W        = 10;

   // stream payloads
   localparam int IN_DATA_W  = 8;
   localparam int OUT_DATA_W = 40;
   localparam int OUT_PAD_W  = OUT_DATA_W - PIX_W - ROW_W - OCOL_W;
   localparam int OUT_USER_W = 2;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FW_W-1:0] FW_RESET = FW_W'(30);
   localparam logic [FH_W-1:0] FH_RESET = FH_W'(20);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // position flags of the item being worked on
   typedef struct packed {
      logic first_row;
      logic top_up;
      logic has_left;
      logic left2;
      logic last_col;
      logic last_row;
   } item_flags_type;

endpackage

>>> hdl/four_neighbour_deglitch_filter_unit.sv
// ---------------------------------------------------------------------------
// four_neighbour_deglitch_filter_unit
// A pixel is taken in only while the unit is idle. Its results are worked in
// turn by the one shared filter unit (compare/sum stage and divide/round
// stage) and leave through the output register, and an output stall holds
// the unit. A first-row pixel gives no result and any other pixel one; a
// last-row pixel past column 0 gives a second one and the frame's final
// pixel a third. Reset: frame size 30 x 20, position at row 0 column 0;
// the two row stores are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module four_neighbour_deglitch_filter_unit #(
   parameter int MAX_WIDTH = fndf_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fndf_pkg::IN_DATA_W-1:0]      req_tdata,   // [7:0] pixel_in
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] pixel_out, [23:8] out_row, [33:24] out_col, [39:34] zero
   output logic [fndf_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   output logic [fndf_pkg::OUT_USER_W-1:0]     rsp_tuser,   // [0] was_replaced, [1] end_of_frame
   output logic                                rsp_tlast,   // last_of_run
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fndf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fndf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fndf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PIX_W  = fndf_pkg::PIX_W;
   localparam int SUM_W  = fndf_pkg::SUM_W;
   localparam int CNT_W  = fndf_pkg::CNT_W;
   localparam int PROD_W = fndf_pkg::PROD_W;
   localparam int ROW_W  = fndf_pkg::ROW_W;
   localparam int FW_W   = fndf_pkg::FW_W;
   localparam int FH_W   = fndf_pkg::FH_W;
   localparam int OCOL_W = fndf_pkg::OCOL_W;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int CMPW   = (WW > FW_W) ? WW : FW_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_A1,
      ST_B1,
      ST_A2,
      ST_B2,
      ST_A3,
      ST_B3
   } state_type;

   // control registers
   state_type         state_ff,    state_in;
   logic [FW_W-1:0]   fw_ff,       fw_in;
   logic [FH_W-1:0]   fh_ff,       fh_in;
   logic [CW-1:0]     col_cnt_ff,  col_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff,  row_cnt_in;
   logic [PIX_W-1:0]  lft_ff,      lft_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff,  rsp_pix_in;
   logic [ROW_W-1:0]  rsp_row_ff,  rsp_row_in;
   logic [OCOL_W-1:0] rsp_col_ff,  rsp_col_in;
   logic              rsp_rep_ff,  rsp_rep_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_eof_ff,  rsp_eof_in;

   // item and datapath registers
   logic [PIX_W-1:0]         px_ff,        px_in;
   logic [PIX_W-1:0]         prev_px_ff,   prev_px_in;
   logic [ROW_W-1:0]         item_row_ff,  item_row_in;
   logic [CW-1:0]            item_col_ff,  item_col_in;
   fndf_pkg::item_flags_type flags_ff,     flags_in;
   logic [PIX_W-1:0]         raw_ahead_ff, raw_ahead_in;
   logic [PIX_W-1:0]         upl_ff,       upl_in;
   logic [PIX_W-1:0]         lrl_ff,       lrl_in;
   logic                     stg_close_ff, stg_close_in;
   logic [PIX_W-1:0]         stg_centre_ff, stg_centre_in;
   logic [SUM_W-1:0]         stg_sum_ff,   stg_sum_in;
   logic [CNT_W-1:0]         stg_cnt_ff,   stg_cnt_in;
   logic [PROD_W-1:0]        stg_prod_ff,  stg_prod_in;

   // combinational signals
   logic              req_acc;
   logic              csr_wr;
   logic              slot_free;
   logic              stg_load;
   logic [PIX_W-1:0]  req_pix;
   logic [CMPW-1:0]   fw_x;
   logic [CMPW-1:0]   eff_w_x;
   logic [WW-1:0]     ew_m1;
   logic [FH_W-1:0]   eh_m1;
   logic              cnt_last_col;
   logic              cnt_last_row;
   logic [CW-1:0]     raw_rd_addr;
   logic [PIX_W-1:0]  raw_rd_data;
   logic [PIX_W-1:0]  corr_rd_data;
   logic              corr_we;

   logic [PIX_W-1:0]  a_centre;
   logic [PIX_W-1:0]  nb_val [4];
   logic [3:0]        nb_mask;
   logic              a_close;
   logic [SUM_W-1:0]  a_sum;
   logic [CNT_W-1:0]  a_cnt;
   logic [PIX_W:0]    ce_x;
   logic [PIX_W:0]    ne_x;

   logic [SUM_W-1:0]  q3;
   logic [SUM_W-1:0]  rem3;
   logic [SUM_W-1:0]  b_q;
   logic              b_up;
   logic [PIX_W-1:0]  res_pix;
   logic              res_rep;

   assign req_pix   = req_tdata[PIX_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc   = req_tvalid & req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr    = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // effective frame size
   always_comb begin
      fw_x = CMPW'(fw_ff);
      if (fw_x < CMPW'(2)) begin
         eff_w_x = CMPW'(2);
      end else if (fw_x > CMPW'(MAX_WIDTH)) begin
         eff_w_x = CMPW'(MAX_WIDTH);
      end else begin
         eff_w_x = fw_x;
      end
      ew_m1 = WW'(eff_w_x - CMPW'(1));
      eh_m1 = (fh_ff < FH_W'(2)) ? FH_W'(1) : fh_ff - FH_W'(1);
   end

   assign cnt_last_col = (WW'(col_cnt_ff) == ew_m1);
   assign cnt_last_row = (row_cnt_ff == eh_m1);
   // prefetch the raw value right of the next pixel, wrapping to column 0
   assign raw_rd_addr  = cnt_last_col ? '0 : col_cnt_ff + CW'(1);

   fndf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (col_cnt_ff),
      .wr_data (req_pix),
      .rd_en   (req_acc),
      .rd_addr (raw_rd_addr),
      .rd_data (raw_rd_data)
   );

   fndf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_corr_ram (
      .clock   (clock),
      .wr_en   (corr_we),
      .wr_addr (item_col_ff),
      .wr_data (res_pix),
      .rd_en   (req_acc),
      .rd_addr (col_cnt_ff),
      .rd_data (corr_rd_data)
   );

   // filter stage a: operand select, neighbour compare and sum
   always_comb begin
      a_centre  = px_ff;
      nb_val[0] = px_ff;
      nb_val[1] = '0;
      nb_val[2] = '0;
      nb_val[3] = '0;
      nb_mask   = 4'b0000;
      case (state_ff)
         ST_A1: begin
            // pixel of the row above: down, right, up, left
            a_centre  = raw_ahead_ff;
            nb_val[1] = raw_rd_data;
            nb_val[2] = corr_rd_data;
            nb_val[3] = lft_ff;
            nb_mask   = {flags_ff.has_left, flags_ff.top_up, !flags_ff.last_col, 1'b1};
         end
         ST_A2: begin
            // last-row pixel left of the input: right, up, left
            a_centre  = prev_px_ff;
            nb_val[1] = upl_ff;
            nb_val[2] = lrl_ff;
            nb_mask   = {1'b0, flags_ff.left2, 1'b1, 1'b1};
         end
         ST_A3: begin
            // final pixel of the frame: up and left
            a_centre  = px_ff;
            nb_val[0] = lft_ff;
            nb_val[1] = lrl_ff;
            nb_mask   = 4'b0011;
         end
         default: begin
            nb_mask = 4'b0000;
         end
      endcase

      a_close = 1'b0;
      a_sum   = '0;
      a_cnt   = '0;
      ce_x    = {1'b0, a_centre};
      for (int i = 0; i < 4; i++) begin
         ne_x = {1'b0, nb_val[i]};
         if (nb_mask[i]) begin
            a_sum = a_sum + SUM_W'(nb_val[i]);
            a_cnt = a_cnt + CNT_W'(1);
            if ((ce_x == ne_x) || (ce_x == ne_x + 1'b1) || (ne_x == ce_x + 1'b1)) begin
               a_close = 1'b1;
            end
         end
      end
   end

   // stage registers load in the a states and hold while a result waits
   assign stg_load      = (state_ff == ST_A1) || (state_ff == ST_A2) || (state_ff == ST_A3);
   assign stg_close_in  = stg_load ? a_close : stg_close_ff;
   assign stg_centre_in = stg_load ? a_centre : stg_centre_ff;
   assign stg_sum_in    = stg_load ? a_sum : stg_sum_ff;
   assign stg_cnt_in    = stg_load ? a_cnt : stg_cnt_ff;
   assign stg_prod_in   = stg_load ? ({{(PROD_W-SUM_W){1'b0}}, a_sum}
                                      * PROD_W'(fndf_pkg::DIV3_MUL))
                                   : stg_prod_ff;

   // filter stage b: mean rounded to nearest, ties to even; the centre stays when a neighbour is close
   assign q3   = stg_prod_ff[PROD_W-1:fndf_pkg::DIV3_SHIFT];
   assign rem3 = stg_sum_ff - {q3[SUM_W-2:0], 1'b0} - q3;

   always_comb begin
      b_q  = '0;
      b_up = 1'b0;
      case (stg_cnt_ff)
         CNT_W'(2): begin
            b_q  = stg_sum_ff >> 1;
            b_up = stg_sum_ff[0] & b_q[0];
         end
         CNT_W'(3): begin
            b_q  = q3;
            b_up = (rem3 == SUM_W'(2));
         end
         CNT_W'(4): begin
            b_q  = stg_sum_ff >> 2;
            b_up = (stg_sum_ff[1:0] == 2'd3) || ((stg_sum_ff[1:0] == 2'd2) && b_q[0]);
         end
         default: begin
            b_q  = '0;
            b_up = 1'b0;
         end
      endcase
      res_pix = stg_close_ff ? stg_centre_ff : PIX_W'(b_q + SUM_W'(b_up));
      res_rep = !stg_close_ff;
   end

   assign corr_we = (state_ff == ST_B1) && slot_free;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      lft_in       = lft_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_rep_in   = rsp_rep_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eof_in   = rsp_eof_ff;
      px_in        = px_ff;
      prev_px_in   = prev_px_ff;
      item_row_in  = item_row_ff;
      item_col_in  = item_col_ff;
      flags_in     = flags_ff;
      raw_ahead_in = raw_ahead_ff;
      upl_in       = upl_ff;
      lrl_in       = lrl_ff;

      if (req_acc) begin
         px_in              = req_pix;
         prev_px_in         = px_ff;
         item_row_in        = row_cnt_ff;
         item_col_in        = col_cnt_ff;
         flags_in.first_row = (row_cnt_ff == '0);
         flags_in.top_up    = (row_cnt_ff > ROW_W'(1));
         flags_in.has_left  = (col_cnt_ff != '0);
         flags_in.left2     = (col_cnt_ff > CW'(1));
         flags_in.last_col  = cnt_last_col;
         flags_in.last_row  = cnt_last_row;
         if (cnt_last_col) begin
            col_cnt_in = '0;
            row_cnt_in = cnt_last_row ? '0 : row_cnt_ff + ROW_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + CW'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_A1;
            end
         end
         ST_A1: begin
            raw_ahead_in = raw_rd_data;
            state_in     = flags_ff.first_row ? ST_IDLE : ST_B1;
         end
         ST_B1: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix;
               rsp_row_in   = item_row_ff - ROW_W'(1);
               rsp_col_in   = OCOL_W'(item_col_ff);
               rsp_rep_in   = res_rep;
               rsp_last_in  = !(flags_ff.last_row && flags_ff.has_left);
               rsp_eof_in   = 1'b0;
               lft_in       = res_pix;
               upl_in       = lft_ff;
               state_in     = (flags_ff.last_row && flags_ff.has_left) ? ST_A2 : ST_IDLE;
            end
         end
         ST_A2: begin
            state_in = ST_B2;
         end
         ST_B2: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix;
               rsp_row_in   = item_row_ff;
               rsp_col_in   = OCOL_W'(item_col_ff - CW'(1));
               rsp_rep_in   = res_rep;
               rsp_last_in  = !flags_ff.last_col;
               rsp_eof_in   = 1'b0;
               lrl_in       = res_pix;
               state_in     = flags_ff.last_col ? ST_A3 : ST_IDLE;
            end
         end
         ST_A3: begin
            state_in = ST_B3;
         end
         ST_B3: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix;
               rsp_row_in   = item_row_ff;
               rsp_col_in   = OCOL_W'(item_col_ff);
               rsp_rep_in   = res_rep;
               rsp_last_in  = 1'b1;
               rsp_eof_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any register write restarts the frame
      if (csr_wr) begin
         case (fndf_pkg::csr_index_type'(csr_paddr[2]))
            fndf_pkg::CSR_FRAME_WIDTH:  fw_in = csr_pwdata[FW_W-1:0];
            fndf_pkg::CSR_FRAME_HEIGHT: fh_in = csr_pwdata[FH_W-1:0];
            default:                    fw_in = fw_ff;
         endcase
         col_cnt_in = '0;
         row_cnt_in = '0;
         lft_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= rsp_pix_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_rep_ff  <= rsp_rep_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eof_ff  <= rsp_eof_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fw_ff        <= fndf_pkg::FW_RESET;
         fh_ff        <= fndf_pkg::FH_RESET;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         lft_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         lft_ff       <= lft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      prev_px_ff    <= prev_px_in;
      item_row_ff   <= item_row_in;
      item_col_ff   <= item_col_in;
      flags_ff      <= flags_in;
      raw_ahead_ff  <= raw_ahead_in;
      upl_ff        <= upl_in;
      lrl_ff        <= lrl_in;
      stg_close_ff  <= stg_close_in;
      stg_centre_ff <= stg_centre_in;
      stg_sum_ff    <= stg_sum_in;
      stg_cnt_ff    <= stg_cnt_in;
      stg_prod_ff   <= stg_prod_in;
   end

   // register read back
   always_comb begin
      case (fndf_pkg::csr_index_type'(csr_paddr[2]))
         fndf_pkg::CSR_FRAME_WIDTH:  csr_prdata = fndf_pkg::CSR_DATA_W'(fw_ff);
         fndf_pkg::CSR_FRAME_HEIGHT: csr_prdata = fndf_pkg::CSR_DATA_W'(fh_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{fndf_pkg::OUT_PAD_W{1'b0}}, rsp_col_ff, rsp_row_ff, rsp_pix_ff};
   assign rsp_tuser  = {rsp_eof_ff, rsp_rep_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/fndf_ram.sv
// ---------------------------------------------------------------------------
// fndf_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fndf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
